// ----- rtl/oohtp_pkg.sv -----
// Package with shared types, constants and lookup functions of the Ogg Opus header parser.
package oohtp_pkg;

    localparam int TAG_STORE_BYTES_DEFAULT = 128;
    localparam int VENDOR_LIMIT_W = 16;
    localparam int COMMENT_LIMIT_W = 25;
    localparam int CFG_DATA_W = 25;
    localparam int CFG_INDEX_W = 2;
    localparam int OUT_TDATA_W = 80;
    localparam int OUT_FIELDS_W = 73;

    localparam logic [15:0] VENDOR_LIMIT_RESET = 16'd1024;
    localparam logic [24:0] COMMENT_LIMIT_RESET = 25'd16777216;

    localparam logic [31:0] OGG_WORD = 32'h5367674f;
    localparam logic [31:0] OPUS_WORD = 32'h7375704f;
    localparam logic [31:0] HEAD_WORD = 32'h64616548;
    // "OpusTags" with the first character in the lowest byte.
    localparam logic [63:0] TAGS_TEXT = 64'h736761547375704f;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_VENDOR_LIMIT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COMMENT_LIMIT = 2'd1;

    // Result kinds.
    typedef enum logic [2:0] {
        KIND_HEADER = 3'd0,
        KIND_TAG_BYTE = 3'd1,
        KIND_TAG_END = 3'd2,
        KIND_TAG_CANCEL = 3'd3,
        KIND_DONE = 3'd4
    } kind_t;

    // Result payload, last field in the lowest bits.
    typedef struct packed {
        logic [7:0] tag_byte;
        logic [2:0] tag_key;
        logic [3:0] layout_class;
        logic [31:0] input_rate;
        logic [7:0] mapping_family;
        logic [7:0] channel_count;
        logic [7:0] version_number;
        logic version_valid;
        logic detected;
    } res_data_t;

    typedef struct packed {
        logic last;
        kind_t kind;
        res_data_t data;
    } res_t;

    // Byte n of the "OpusTags" signature.
    function automatic logic [7:0] tags_char(input logic [2:0] idx);
        return TAGS_TEXT[idx*8 +: 8];
    endfunction

    // Length of each key text including the equals sign.
    function automatic logic [3:0] key_len(input logic [2:0] k);
        case (k)
            3'd0: return 4'd7;
            3'd1: return 4'd6;
            3'd2: return 4'd6;
            3'd3: return 4'd6;
            default: return 4'd9;
        endcase
    endfunction

    // Character of a key text at a position; positions past the key give zero.
    function automatic logic [7:0] key_char(input logic [2:0] k, input logic [3:0] pos);
        logic [71:0] text;
        begin
            case (k)
                3'd0: text = {16'h0, "=tsitra"};
                3'd1: text = {24'h0, "=eltit"};
                3'd2: text = {24'h0, "=mubla"};
                3'd3: text = {24'h0, "=erneg"};
                default: text = "=resopmoc";
            endcase
            return (pos < 4'd9) ? text[pos*8 +: 8] : 8'h00;
        end
    endfunction

    // Channel layout class from channel count and mapping family.
    function automatic logic [3:0] layout_of(input logic [7:0] ch, input logic [7:0] map);
        if (map == 8'd0)
            return (ch == 8'd1 || ch == 8'd2) ? ch[3:0] : 4'd0;
        else if (map == 8'd1)
            return (ch >= 8'd1 && ch <= 8'd8) ? ch[3:0] : 4'd0;
        else
            return 4'd9;
    endfunction

endpackage

// ----- rtl/ogg_opus_header_tag_parser.sv -----
// Top level of the Ogg Opus identification header and comment tag parser.
//
// Usage: captured file bytes enter on the s_axis channel, one byte per transfer,
// with tlast set on the final captured byte. The parser checks the first Ogg
// page and its OpusHead body, then the second page with OpusTags, and reports
// on the m_axis channel: a header info result, value bytes of artist, title,
// album, genre and composer comments, tag end and tag cancel marks, and a final
// done result. tuser gives the result kind; tlast marks the last result caused
// by one input byte. One input byte causes at most two results.
// Results are registered: the results of a byte enter the result queue when it is taken.
// Throughput: one byte per cycle; the rate is set by the four-entry result
// queue, which takes a byte whenever it has room for two results, so a run of
// bytes that each cause two results drains at one result per cycle unless stalled.
// Configuration writes on cfg_we take effect at once.
// Reset clears the parse to the start of page one, empties the queue and
// loads the default limits. When the receiver stalls, results wait in the
// queue and s_axis_tready falls once fewer than two entries are free.
// After the done result every further byte is taken and dropped until reset.
module ogg_opus_header_tag_parser #(
    parameter int TAG_STORE_BYTES = oohtp_pkg::TAG_STORE_BYTES_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    // Input stream; tdata: data_byte[7:0].  tlast: end_of_capture.
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    input  logic [7:0] s_axis_tdata,
    input  logic s_axis_tlast,
    // Result stream; tdata: detected[0], version_valid[1], version_number[9:2],
    // channel_count[17:10], mapping_family[25:18], input_rate[57:26],
    // layout_class[61:58], tag_key[64:62], tag_byte[72:65], zero fill above.
    // tuser: kind[2:0].  tlast: last_in_run.
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    output logic [oohtp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [2:0] m_axis_tuser,
    output logic m_axis_tlast,
    // Configuration write port.
    input  logic cfg_we,
    input  logic [oohtp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [oohtp_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int VBS_W = $clog2(TAG_STORE_BYTES);
    localparam logic [VBS_W-1:0] VBS_MAX = VBS_W'(TAG_STORE_BYTES - 1);

    typedef enum logic [11:0] {
        PH_P1_HDR    = 12'b000000000001,
        PH_P1_LACE   = 12'b000000000010,
        PH_HEAD_BODY = 12'b000000000100,
        PH_P2_HDR    = 12'b000000001000,
        PH_P2_LACE   = 12'b000000010000,
        PH_TAG_MAGIC = 12'b000000100000,
        PH_VLEN      = 12'b000001000000,
        PH_VSKIP     = 12'b000010000000,
        PH_COUNT     = 12'b000100000000,
        PH_CLEN      = 12'b001000000000,
        PH_COMMENT   = 12'b010000000000,
        PH_DONE      = 12'b100000000000
    } phase_t;

    // Parser state.
    phase_t phase_reg, phase_next;
    logic [8:0] pos_reg, pos_next;
    logic [7:0] seg_reg, seg_next;
    logic [15:0] bsize_reg, bsize_next;
    logic [15:0] brem_reg, brem_next;
    logic [31:0] wa_reg, wa_next;
    logic [7:0] ver_reg, ver_next;
    logic [7:0] ch_reg, ch_next;
    logic [7:0] map_reg, map_next;
    logic [31:0] rate_reg, rate_next;
    logic [31:0] cleft_reg, cleft_next;
    logic [24:0] crem_reg, crem_next;
    logic [4:0] mask_reg, mask_next;
    logic [VBS_W-1:0] vbs_reg, vbs_next;
    logic det_reg, det_next;
    logic topen_reg, topen_next;
    logic [2:0] tkey_reg, tkey_next;
    logic [15:0] vlim_reg;
    logic [24:0] clim_reg;

    // Result queue.
    oohtp_pkg::res_t q_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;

    logic in_fire, out_fire;
    logic ev_header, ev_byte, ev_end, ev_finish, cancel;
    logic [7:0] ev_val;
    logic [2:0] ev_key, cancel_key;
    logic [31:0] wa_new;
    logic [7:0] lb;
    logic found;
    oohtp_pkg::res_t r0, r1;
    logic [1:0] nres;

    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (cnt_reg <= 3'd2);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vlim_reg <= oohtp_pkg::VENDOR_LIMIT_RESET;
            clim_reg <= oohtp_pkg::COMMENT_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == oohtp_pkg::REG_VENDOR_LIMIT)
                vlim_reg <= cfg_data[15:0];
            else if (cfg_index == oohtp_pkg::REG_COMMENT_LIMIT)
                clim_reg <= cfg_data;
        end
    end

    // Per-byte parse step.
    always_comb
    begin
        phase_next = phase_reg;
        pos_next = pos_reg;
        seg_next = seg_reg;
        bsize_next = bsize_reg;
        brem_next = brem_reg;
        wa_next = wa_reg;
        ver_next = ver_reg;
        ch_next = ch_reg;
        map_next = map_reg;
        rate_next = rate_reg;
        cleft_next = cleft_reg;
        crem_next = crem_reg;
        mask_next = mask_reg;
        vbs_next = vbs_reg;
        det_next = det_reg;
        topen_next = topen_reg;
        tkey_next = tkey_reg;
        ev_header = 1'b0;
        ev_byte = 1'b0;
        ev_end = 1'b0;
        ev_finish = 1'b0;
        cancel = 1'b0;
        cancel_key = 3'd0;
        ev_val = 8'd0;
        ev_key = 3'd0;
        found = 1'b0;
        wa_new = wa_reg | (32'(s_axis_tdata) << {pos_reg[1:0], 3'b000});
        lb = (s_axis_tdata >= 8'h41 && s_axis_tdata <= 8'h5a) ? s_axis_tdata + 8'd32
                                                              : s_axis_tdata;

        unique case (phase_reg) inside
            PH_P1_HDR, PH_P2_HDR:
            begin
                if (pos_reg < 9'd4)
                begin
                    if (s_axis_tdata != oohtp_pkg::OGG_WORD[pos_reg[1:0]*8 +: 8])
                    begin
                        phase_next = PH_DONE;
                        ev_finish = 1'b1;
                    end
                    else
                        pos_next = pos_reg + 9'd1;
                end
                else if (pos_reg >= 9'd26)
                begin
                    if (s_axis_tdata == 8'd0)
                    begin
                        phase_next = PH_DONE;
                        ev_finish = 1'b1;
                    end
                    else
                    begin
                        seg_next = s_axis_tdata;
                        bsize_next = 16'd0;
                        pos_next = 9'd0;
                        phase_next = (phase_reg == PH_P2_HDR) ? PH_P2_LACE : PH_P1_LACE;
                    end
                end
                else
                    pos_next = pos_reg + 9'd1;
            end
            PH_P1_LACE, PH_P2_LACE:
            begin
                bsize_next = bsize_reg + 16'(s_axis_tdata);
                pos_next = pos_reg + 9'd1;
                if (pos_next >= 9'(seg_reg))
                begin
                    if (bsize_next < ((phase_reg == PH_P2_LACE) ? 16'd12 : 16'd19))
                    begin
                        phase_next = PH_DONE;
                        ev_finish = 1'b1;
                    end
                    else
                    begin
                        brem_next = bsize_next;
                        pos_next = 9'd0;
                        wa_next = 32'd0;
                        phase_next = (phase_reg == PH_P2_LACE) ? PH_TAG_MAGIC : PH_HEAD_BODY;
                    end
                end
            end
            PH_HEAD_BODY:
            begin
                if (pos_reg < 9'd8 && s_axis_tdata != (pos_reg < 9'd4
                        ? oohtp_pkg::OPUS_WORD[pos_reg[1:0]*8 +: 8]
                        : oohtp_pkg::HEAD_WORD[pos_reg[1:0]*8 +: 8]))
                begin
                    phase_next = PH_DONE;
                    ev_finish = 1'b1;
                end
                else
                begin
                    if (pos_reg == 9'd8)
                        ver_next = s_axis_tdata;
                    if (pos_reg == 9'd9)
                        ch_next = s_axis_tdata;
                    if (pos_reg >= 9'd12 && pos_reg <= 9'd15)
                    begin
                        wa_next = wa_new;
                        if (pos_reg == 9'd15)
                            rate_next = wa_new;
                    end
                    if (pos_reg == 9'd18)
                        map_next = s_axis_tdata;
                    if (pos_reg < 9'd511)
                        pos_next = pos_reg + 9'd1;
                    if (brem_reg != 16'd0)
                        brem_next = brem_reg - 16'd1;
                    if (brem_next == 16'd0)
                    begin
                        det_next = 1'b1;
                        ev_header = 1'b1;
                        phase_next = PH_P2_HDR;
                        pos_next = 9'd0;
                    end
                end
            end
            PH_TAG_MAGIC:
            begin
                if (s_axis_tdata != oohtp_pkg::tags_char(pos_reg[2:0]))
                begin
                    phase_next = PH_DONE;
                    ev_finish = 1'b1;
                end
                else
                begin
                    if (brem_reg != 16'd0)
                        brem_next = brem_reg - 16'd1;
                    pos_next = pos_reg + 9'd1;
                    if (pos_next >= 9'd8)
                    begin
                        phase_next = PH_VLEN;
                        pos_next = 9'd0;
                        wa_next = 32'd0;
                    end
                end
            end
            PH_VLEN, PH_COUNT, PH_CLEN:
            begin
                wa_next = wa_new;
                pos_next = pos_reg + 9'd1;
                if (brem_reg != 16'd0)
                    brem_next = brem_reg - 16'd1;
                if (pos_next >= 9'd4)
                begin
                    if (phase_reg == PH_VLEN)
                    begin
                        if (wa_new > 32'(vlim_reg) || 32'(brem_next) < wa_new)
                        begin
                            phase_next = PH_DONE;
                            ev_finish = 1'b1;
                        end
                        else if (wa_new == 32'd0)
                        begin
                            if (brem_next < 16'd4)
                            begin
                                phase_next = PH_DONE;
                                ev_finish = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_COUNT;
                                pos_next = 9'd0;
                                wa_next = 32'd0;
                            end
                        end
                        else
                        begin
                            crem_next = wa_new[24:0];
                            phase_next = PH_VSKIP;
                        end
                    end
                    else if (phase_reg == PH_CLEN &&
                             (wa_new > 32'(clim_reg) || 32'(brem_next) < wa_new))
                    begin
                        phase_next = PH_DONE;
                        ev_finish = 1'b1;
                    end
                    else if (phase_reg == PH_CLEN && wa_new != 32'd0)
                    begin
                        crem_next = wa_new[24:0];
                        mask_next = 5'h1f;
                        pos_next = 9'd0;
                        vbs_next = '0;
                        topen_next = 1'b0;
                        phase_next = PH_COMMENT;
                    end
                    else
                    begin
                        // Next comment; end when none left or body under 4 bytes.
                        if (phase_reg == PH_COUNT)
                            cleft_next = wa_new;
                        if (cleft_next == 32'd0 || brem_next < 16'd4)
                        begin
                            phase_next = PH_DONE;
                            ev_finish = 1'b1;
                        end
                        else
                        begin
                            cleft_next = cleft_next - 32'd1;
                            phase_next = PH_CLEN;
                            pos_next = 9'd0;
                            wa_next = 32'd0;
                        end
                    end
                end
            end
            PH_VSKIP:
            begin
                if (brem_reg != 16'd0)
                    brem_next = brem_reg - 16'd1;
                if (crem_reg != 25'd0)
                    crem_next = crem_reg - 25'd1;
                if (crem_next == 25'd0)
                begin
                    if (brem_next < 16'd4)
                    begin
                        phase_next = PH_DONE;
                        ev_finish = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_COUNT;
                        pos_next = 9'd0;
                        wa_next = 32'd0;
                    end
                end
            end
            PH_COMMENT:
            begin
                if (brem_reg != 16'd0)
                    brem_next = brem_reg - 16'd1;
                if (crem_reg != 25'd0)
                    crem_next = crem_reg - 25'd1;
                if (topen_reg)
                begin
                    if (vbs_reg < VBS_MAX)
                    begin
                        ev_byte = 1'b1;
                        ev_val = s_axis_tdata;
                        ev_key = tkey_reg;
                        vbs_next = vbs_reg + 1'b1;
                    end
                end
                else if (mask_reg != 5'd0)
                begin
                    // Match all still live keys against this byte, first full match wins.
                    for (int k = 0; k < 5; k++)
                    begin
                        if (!found && mask_next[k])
                        begin
                            if (pos_reg >= 9'(oohtp_pkg::key_len(3'(k))) ||
                                lb != oohtp_pkg::key_char(3'(k), pos_reg[3:0]))
                                mask_next[k] = 1'b0;
                            else if (pos_reg + 9'd1 == 9'(oohtp_pkg::key_len(3'(k))))
                            begin
                                found = 1'b1;
                                topen_next = 1'b1;
                                tkey_next = 3'(k);
                                mask_next = 5'd0;
                                vbs_next = '0;
                            end
                        end
                    end
                    pos_next = pos_reg + 9'd1;
                end
                if (crem_next == 25'd0)
                begin
                    if (topen_next)
                    begin
                        ev_end = 1'b1;
                        ev_key = tkey_next;
                        topen_next = 1'b0;
                    end
                    if (cleft_reg == 32'd0 || brem_next < 16'd4)
                    begin
                        phase_next = PH_DONE;
                        ev_finish = 1'b1;
                    end
                    else
                    begin
                        cleft_next = cleft_reg - 32'd1;
                        phase_next = PH_CLEN;
                        pos_next = 9'd0;
                        wa_next = 32'd0;
                    end
                end
            end
            PH_DONE:
            begin
            end
            default:
            begin
            end
        endcase

        // End of capture closes a running parse.
        if (s_axis_tlast && phase_next != PH_DONE && phase_reg != PH_DONE)
        begin
            if (topen_next)
            begin
                cancel = 1'b1;
                cancel_key = tkey_next;
                ev_byte = 1'b0;
                topen_next = 1'b0;
            end
            phase_next = PH_DONE;
            ev_finish = 1'b1;
        end
        if (ev_byte && ev_end && ev_finish)
            ev_end = 1'b0;
    end

    // Order the results of this byte into at most two queue entries.
    always_comb
    begin
        oohtp_pkg::res_t rs [5];
        logic [4:0] ev;
        for (int i = 0; i < 5; i++)
            rs[i] = '0;
        rs[0].kind = oohtp_pkg::KIND_HEADER;
        rs[0].data.detected = 1'b1;
        rs[0].data.version_valid = (ver_next == 8'd1);
        rs[0].data.version_number = ver_next;
        rs[0].data.channel_count = ch_next;
        rs[0].data.mapping_family = map_next;
        rs[0].data.input_rate = rate_next;
        rs[0].data.layout_class = oohtp_pkg::layout_of(ch_next, map_next);
        rs[1].kind = oohtp_pkg::KIND_TAG_BYTE;
        rs[1].data.tag_key = ev_key;
        rs[1].data.tag_byte = ev_val;
        rs[2].kind = oohtp_pkg::KIND_TAG_END;
        rs[2].data.tag_key = ev_key;
        rs[3].kind = oohtp_pkg::KIND_TAG_CANCEL;
        rs[3].data.tag_key = cancel_key;
        rs[4].kind = oohtp_pkg::KIND_DONE;
        rs[4].data.detected = det_next;
        ev = {ev_finish, cancel, ev_end, ev_byte, ev_header};
        r0 = '0;
        r1 = '0;
        nres = 2'd0;
        for (int i = 0; i < 5; i++)
        begin
            if (ev[i])
            begin
                if (nres == 2'd0)
                    r0 = rs[i];
                else
                    r1 = rs[i];
                nres = nres + 2'd1;
            end
        end
        if (nres == 2'd1)
            r0.last = 1'b1;
        r1.last = 1'b1;
        if (phase_reg == PH_DONE)
            nres = 2'd0;
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_P1_HDR;
            pos_reg <= 9'd0;
            seg_reg <= 8'd0;
            bsize_reg <= 16'd0;
            brem_reg <= 16'd0;
            wa_reg <= 32'd0;
            ver_reg <= 8'd0;
            ch_reg <= 8'd0;
            map_reg <= 8'd0;
            rate_reg <= 32'd0;
            cleft_reg <= 32'd0;
            crem_reg <= 25'd0;
            mask_reg <= 5'h1f;
            vbs_reg <= '0;
            det_reg <= 1'b0;
            topen_reg <= 1'b0;
            tkey_reg <= 3'd0;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            pos_reg <= pos_next;
            seg_reg <= seg_next;
            bsize_reg <= bsize_next;
            brem_reg <= brem_next;
            wa_reg <= wa_next;
            ver_reg <= ver_next;
            ch_reg <= ch_next;
            map_reg <= map_next;
            rate_reg <= rate_next;
            cleft_reg <= cleft_next;
            crem_reg <= crem_next;
            mask_reg <= mask_next;
            vbs_reg <= vbs_next;
            det_reg <= det_next;
            topen_reg <= topen_next;
            tkey_reg <= tkey_next;
        end
    end

    // Result queue pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 2'd0;
            rp_reg <= 2'd0;
            cnt_reg <= 3'd0;
        end
        else
        begin
            if (in_fire)
                wp_reg <= wp_reg + nres;
            if (out_fire)
                rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + (in_fire ? 3'(nres) : 3'd0) - (out_fire ? 3'd1 : 3'd0);
        end
    end

    // Result queue storage.
    always_ff @(posedge clk)
    begin
        if (in_fire && nres != 2'd0)
            q_reg[wp_reg] <= r0;
        if (in_fire && nres == 2'd2)
            q_reg[wp_reg + 2'd1] <= r1;
    end

    assign m_axis_tvalid = (cnt_reg != 3'd0);
    assign m_axis_tdata = {{(oohtp_pkg::OUT_TDATA_W - oohtp_pkg::OUT_FIELDS_W){1'b0}},
                           q_reg[rp_reg].data};
    assign m_axis_tuser = q_reg[rp_reg].kind;
    assign m_axis_tlast = q_reg[rp_reg].last;

endmodule

// ----- rtl/oohtp_checker.sv -----
// Port-level checker of the Ogg Opus header parser, bound to the top level.
module oohtp_checker (
    input logic clk,
    input logic rst_n,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [oohtp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [2:0] m_axis_tuser,
    input logic m_axis_tlast
);

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

    // Header info always reports a detected header.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == oohtp_pkg::KIND_HEADER |-> m_axis_tdata[0])
    else $error("header info without detected");

    // A tag cancel is never last in its run; done follows it.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == oohtp_pkg::KIND_TAG_CANCEL |-> !m_axis_tlast)
    else $error("tag cancel closed a run");

    // Nothing follows the done result.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tuser == oohtp_pkg::KIND_DONE
        |=> !m_axis_tvalid)
    else $error("result after done");

endmodule

bind ogg_opus_header_tag_parser oohtp_checker u_oohtp_checker (
    .clk(clk),
    .rst_n(rst_n),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
);

// ----- sim/tb.sv -----
// Testbench for the Ogg Opus header and comment tag parser.
`timescale 1ns / 1ps

module tb;

    // Parse phases of the predictor.
    typedef enum int {
        PH_P1_HDR, PH_P1_LACE, PH_HEAD_BODY, PH_P2_HDR, PH_P2_LACE, PH_TAG_MAGIC,
        PH_VLEN, PH_VSKIP, PH_COUNT, PH_CLEN, PH_COMMENT, PH_DONE
    } phase_e;

    localparam int VALUE_MAX = oohtp_pkg::TAG_STORE_BYTES_DEFAULT - 1;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int ITEM_TARGET = 550;
    // Items kept for the tests that follow the random comments.
    localparam int TAIL_ITEMS = 110;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic s_axis_tlast = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [oohtp_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic [2:0] m_axis_tuser;
    logic m_axis_tlast;
    logic cfg_we = 1'b0;
    logic [oohtp_pkg::CFG_INDEX_W-1:0] cfg_index = oohtp_pkg::REG_VENDOR_LIMIT;
    logic [oohtp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    ogg_opus_header_tag_parser uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Shared testbench state.
    oohtp_pkg::res_t pending_results[$];
    int err_count = 0;
    int sent_items = 0;
    int stall_cycles = 0;
    bit burst_mode = 1'b0;
    bit hold_req = 1'b0;

    // Parser state mirrored by the predictor.
    logic [15:0] vendor_limit;
    logic [24:0] comment_limit;
    phase_e phase;
    int unsigned pos, seg_count;
    logic [15:0] body_size, body_left;
    logic [31:0] word, comments_left, rate;
    logic [24:0] comment_left;
    logic [7:0] ver, chans, mapping;
    logic [4:0] key_mask;
    int unsigned value_sent;
    bit detected_seen, tag_open;
    logic [2:0] open_key;
    bit ev_header, ev_value, ev_close, ev_done;
    logic [7:0] ev_value_byte;
    logic [2:0] ev_key;

    string key_text[5] = '{"artist=", "title=", "album=", "genre=", "composer="};
    string tags_text = "OpusTags";

    function void end_parse();
        phase = PH_DONE;
        ev_done = 1'b1;
    endfunction

    function void take_body();
        if (body_left != 0) body_left--;
    endfunction

    function void next_comment();
        if (comments_left == 0 || body_left < 4)
        begin
            end_parse();
            return;
        end
        comments_left--;
        phase = PH_CLEN;
        pos = 0;
        word = 0;
    endfunction

    function void start_count();
        if (body_left < 4)
        begin
            end_parse();
            return;
        end
        phase = PH_COUNT;
        pos = 0;
        word = 0;
    endfunction

    // Little-endian word collection; true once four bytes are in.
    function bit gather(logic [7:0] b);
        word = word | (32'(b) << (8 * (pos & 3)));
        pos++;
        take_body();
        return pos >= 4;
    endfunction

    function void page_header(logic [7:0] b, bit second);
        if (pos < 4)
        begin
            if (b != oohtp_pkg::OGG_WORD[8*pos +: 8])
            begin
                end_parse();
                return;
            end
        end
        else if (pos >= 26)
        begin
            if (b == 0)
            begin
                end_parse();
                return;
            end
            seg_count = b;
            body_size = 0;
            pos = 0;
            phase = second ? PH_P2_LACE : PH_P1_LACE;
            return;
        end
        pos++;
    endfunction

    function void lacing(logic [7:0] b, bit second);
        body_size = body_size + b;
        pos++;
        if (pos < seg_count) return;
        if (body_size < (second ? 12 : 19))
        begin
            end_parse();
            return;
        end
        body_left = body_size;
        pos = 0;
        word = 0;
        phase = second ? PH_TAG_MAGIC : PH_HEAD_BODY;
    endfunction

    function void head_body(logic [7:0] b);
        logic [7:0] want;
        if (pos < 8)
        begin
            want = (pos < 4) ? oohtp_pkg::OPUS_WORD[8*pos +: 8]
                             : oohtp_pkg::HEAD_WORD[8*(pos-4) +: 8];
            if (b != want)
            begin
                end_parse();
                return;
            end
        end
        else if (pos == 8) ver = b;
        else if (pos == 9) chans = b;
        else if (pos >= 12 && pos <= 15)
        begin
            word = word | (32'(b) << (8 * (pos - 12)));
            if (pos == 15) rate = word;
        end
        else if (pos == 18) mapping = b;
        if (pos < 511) pos++;
        take_body();
        if (body_left == 0)
        begin
            detected_seen = 1'b1;
            ev_header = 1'b1;
            phase = PH_P2_HDR;
            pos = 0;
        end
    endfunction

    // One byte inside a comment: key matching, then value bytes.
    function void comment_in(logic [7:0] b);
        logic [7:0] lb;
        take_body();
        if (comment_left != 0) comment_left--;
        if (tag_open)
        begin
            if (value_sent < VALUE_MAX)
            begin
                ev_value = 1'b1;
                ev_value_byte = b;
                ev_key = open_key;
                value_sent++;
            end
        end
        else if (key_mask != 0)
        begin
            lb = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
            for (int k = 0; k < 5; k++)
            begin
                if (!key_mask[k]) continue;
                if (pos >= key_text[k].len() || lb != key_text[k][pos])
                    key_mask[k] = 1'b0;
                else if (pos + 1 == key_text[k].len())
                begin
                    tag_open = 1'b1;
                    open_key = 3'(k);
                    key_mask = '0;
                    value_sent = 0;
                    break;
                end
            end
            pos++;
        end
        if (comment_left == 0)
        begin
            if (tag_open)
            begin
                ev_close = 1'b1;
                ev_key = open_key;
                tag_open = 1'b0;
            end
            next_comment();
        end
    endfunction

    function logic [3:0] layout_class_of(logic [7:0] ch, logic [7:0] map);
        if (map == 0) return (ch == 1 || ch == 2) ? ch[3:0] : 4'd0;
        if (map == 1) return (ch >= 1 && ch <= 8) ? ch[3:0] : 4'd0;
        return 4'd9;
    endfunction

    function void parser_reset();
        vendor_limit = oohtp_pkg::VENDOR_LIMIT_RESET;
        comment_limit = oohtp_pkg::COMMENT_LIMIT_RESET;
        phase = PH_P1_HDR;
        pos = 0;
        seg_count = 0;
        body_size = 0;
        body_left = 0;
        word = 0;
        comments_left = 0;
        comment_left = 0;
        value_sent = 0;
        key_mask = 5'h1f;
        ver = 0;
        chans = 0;
        mapping = 0;
        rate = 0;
        detected_seen = 1'b0;
        tag_open = 1'b0;
        open_key = 0;
    endfunction

    // Works out the results of one accepted byte and queues them.
    function void predict_results(logic [7:0] b, bit eoc);
        oohtp_pkg::res_t r[4];
        int n;
        bit cancel;
        logic [2:0] cancel_key;
        logic [31:0] n_len;
        n = 0;
        cancel = 1'b0;
        cancel_key = 0;
        if (phase == PH_DONE) return;
        ev_header = 0;
        ev_value = 0;
        ev_close = 0;
        ev_done = 0;
        ev_value_byte = 0;
        ev_key = 0;
        case (phase)
            PH_P1_HDR: page_header(b, 1'b0);
            PH_P1_LACE: lacing(b, 1'b0);
            PH_HEAD_BODY: head_body(b);
            PH_P2_HDR: page_header(b, 1'b1);
            PH_P2_LACE: lacing(b, 1'b1);
            PH_TAG_MAGIC:
            begin
                if (b != tags_text[pos & 7]) end_parse();
                else
                begin
                    take_body();
                    pos++;
                    if (pos >= 8)
                    begin
                        phase = PH_VLEN;
                        pos = 0;
                        word = 0;
                    end
                end
            end
            PH_VLEN:
            begin
                if (gather(b))
                begin
                    if (word > vendor_limit || body_left < word) end_parse();
                    else if (word == 0) start_count();
                    else
                    begin
                        comment_left = word[24:0];
                        phase = PH_VSKIP;
                    end
                end
            end
            PH_VSKIP:
            begin
                take_body();
                if (comment_left != 0) comment_left--;
                if (comment_left == 0) start_count();
            end
            PH_COUNT:
            begin
                if (gather(b))
                begin
                    comments_left = word;
                    next_comment();
                end
            end
            PH_CLEN:
            begin
                if (gather(b))
                begin
                    n_len = word;
                    if (n_len > comment_limit || body_left < n_len) end_parse();
                    else if (n_len == 0) next_comment();
                    else
                    begin
                        comment_left = n_len[24:0];
                        key_mask = 5'h1f;
                        pos = 0;
                        value_sent = 0;
                        tag_open = 1'b0;
                        phase = PH_COMMENT;
                    end
                end
            end
            PH_COMMENT: comment_in(b);
            default: ;
        endcase
        // End of capture cancels an open tag and closes the parse.
        if (eoc && phase != PH_DONE)
        begin
            if (tag_open)
            begin
                cancel = 1'b1;
                cancel_key = open_key;
                ev_value = 1'b0;
                tag_open = 1'b0;
            end
            end_parse();
        end
        if (ev_value && ev_close && ev_done) ev_close = 1'b0;

        if (ev_header)
        begin
            r[n] = '0;
            r[n].kind = oohtp_pkg::KIND_HEADER;
            r[n].data.detected = 1'b1;
            r[n].data.version_valid = (ver == 1);
            r[n].data.version_number = ver;
            r[n].data.channel_count = chans;
            r[n].data.mapping_family = mapping;
            r[n].data.input_rate = rate;
            r[n].data.layout_class = layout_class_of(chans, mapping);
            n++;
        end
        if (ev_value)
        begin
            r[n] = '0;
            r[n].kind = oohtp_pkg::KIND_TAG_BYTE;
            r[n].data.tag_key = ev_key;
            r[n].data.tag_byte = ev_value_byte;
            n++;
        end
        if (ev_close)
        begin
            r[n] = '0;
            r[n].kind = oohtp_pkg::KIND_TAG_END;
            r[n].data.tag_key = ev_key;
            n++;
        end
        if (cancel)
        begin
            r[n] = '0;
            r[n].kind = oohtp_pkg::KIND_TAG_CANCEL;
            r[n].data.tag_key = cancel_key;
            n++;
        end
        if (ev_done)
        begin
            r[n] = '0;
            r[n].kind = oohtp_pkg::KIND_DONE;
            r[n].data.detected = detected_seen;
            n++;
        end
        if (n > 0) r[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) pending_results.push_back(r[i]);
    endfunction

    // One byte after a random gap (none in burst); returns at the falling edge.
    task automatic push_byte(input logic [7:0] b, input bit eoc);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = b;
        s_axis_tlast = eoc;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        predict_results(b, eoc);
        sent_items++;
        @(negedge clk);
    endtask

    task automatic push_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++) push_byte(w[8*i +: 8], 1'b0);
    endtask

    // Sender pause until every expected result has arrived.
    task automatic wait_results_drained();
        s_axis_tvalid = 1'b0;
        s_axis_tlast = 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [oohtp_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [24:0] val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        if (idx == oohtp_pkg::REG_VENDOR_LIMIT) vendor_limit = val[15:0];
        else if (idx == oohtp_pkg::REG_COMMENT_LIMIT) comment_limit = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // A comment: length word, then key text, then value bytes.
    task automatic push_comment(input string key, input int value_len);
        push_word(32'(key.len() + value_len));
        for (int i = 0; i < key.len(); i++) push_byte(key[i], 1'b0);
        for (int i = 0; i < value_len; i++) push_byte(8'($urandom), 1'b0);
    endtask

    // Mixed-case copy of a key, to check case-blind matching.
    function string mixed_case(string s);
        string t;
        t = s;
        for (int i = 0; i < t.len(); i++)
            if (t[i] >= "a" && t[i] <= "z" && $urandom_range(0, 1)) t[i] = t[i] - 8'd32;
        return t;
    endfunction

    task automatic test_page_one();
        for (int i = 0; i < 4; i++) push_byte(oohtp_pkg::OGG_WORD[8*i +: 8], 1'b0);
        for (int i = 4; i < 26; i++) push_byte(8'($urandom), 1'b0);
        push_byte(8'd3, 1'b0);
        push_byte(8'd10, 1'b0);
        push_byte(8'd5, 1'b0);
        push_byte(8'd4, 1'b0);
        push_word(oohtp_pkg::OPUS_WORD);
        push_word(oohtp_pkg::HEAD_WORD);
        push_byte($urandom_range(0, 1) ? 8'd1 : 8'($urandom), 1'b0);
        push_byte(8'($urandom_range(0, 9)), 1'b0);
        push_byte(8'($urandom), 1'b0);
        push_byte(8'($urandom), 1'b0);
        push_word($urandom);
        push_byte(8'($urandom), 1'b0);
        push_byte(8'($urandom), 1'b0);
        push_byte(8'($urandom_range(0, 2)), 1'b0);
    endtask

    // Second page with a large body, the tags magic, vendor and count.
    task automatic test_page_two_start();
        int vlen;
        vlen = $urandom_range(0, 20);
        for (int i = 0; i < 4; i++) push_byte(oohtp_pkg::OGG_WORD[8*i +: 8], 1'b0);
        for (int i = 4; i < 26; i++) push_byte(8'($urandom), 1'b0);
        push_byte(8'd3, 1'b0);
        for (int i = 0; i < 3; i++) push_byte(8'd255, 1'b0);
        for (int i = 0; i < 8; i++) push_byte(tags_text[i], 1'b0);
        push_word(32'(vlen));
        for (int i = 0; i < vlen; i++) push_byte(8'($urandom), 1'b0);
        push_word(32'd100000);
    endtask

    task automatic test_directed_comments();
        push_comment("ARTIST=", 3);
        push_comment("title=", 0);
        push_word(32'd0);
        push_comment("artisX=", 4);
        push_comment("Genre=", 1);
        push_comment("album=", 2);
        push_comment("composer=", VALUE_MAX + 10);
        push_comment("=", 2);
    endtask

    task automatic test_random_comments();
        string key;
        while (sent_items < ITEM_TARGET - TAIL_ITEMS)
        begin
            burst_mode = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0)
            begin
                key = "xx=";
                key[0] = 8'($urandom);
                key[1] = 8'($urandom);
            end
            else key = mixed_case(key_text[$urandom_range(0, 4)]);
            push_comment(key, $urandom_range(0, 20));
        end
        burst_mode = 1'b0;
    endtask

    // Receiver holds off while value bytes keep coming, so the block stalls.
    task automatic test_backpressure();
        hold_req = 1'b1;
        push_comment("title=", 60);
    endtask

    // Final comment cut by the end of capture while its tag is open.
    task automatic test_cancel_at_end();
        push_comment("artist=", 0);
        push_word(32'd0);
        push_word(32'd50);
        for (int i = 0; i < 7; i++) push_byte(key_text[0][i], 1'b0);
        for (int i = 0; i < 5; i++) push_byte(8'($urandom), 1'b0);
        wait_results_drained();
        write_reg(oohtp_pkg::REG_COMMENT_LIMIT, 25'd0);
        push_byte(8'($urandom), 1'b0);
        push_byte(8'($urandom), 1'b1);
        // After the done result the block drops everything.
        for (int i = 0; i < 5; i++) push_byte(8'($urandom), i[0]);
    endtask

    // Receiver: random hold-off per result, with a long hold on request.
    initial
    begin
        int gap;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            gap = burst_mode ? 0 : $urandom_range(0, 16);
            if (gap > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid) @(posedge clk);
            @(negedge clk);
        end
    end

    // Result checker: each transfer against the oldest expectation.
    always @(posedge clk)
    begin
        oohtp_pkg::res_t want;
        oohtp_pkg::res_data_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[oohtp_pkg::OUT_FIELDS_W-1:0];
            if (pending_results.size() == 0)
            begin
                $error("unexpected result, kind %0d", m_axis_tuser);
                err_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tuser != want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
                    err_count++;
                end
                if (m_axis_tlast != want.last)
                begin
                    $error("last_in_run: expected %0d, got %0d", want.last, m_axis_tlast);
                    err_count++;
                end
                if (got.detected != want.data.detected)
                begin
                    $error("detected: expected %0d, got %0d",
                           want.data.detected, got.detected);
                    err_count++;
                end
                if (got.version_valid != want.data.version_valid)
                begin
                    $error("version_valid: expected %0d, got %0d",
                           want.data.version_valid, got.version_valid);
                    err_count++;
                end
                if (got.version_number != want.data.version_number)
                begin
                    $error("version_number: expected %0d, got %0d",
                           want.data.version_number, got.version_number);
                    err_count++;
                end
                if (got.channel_count != want.data.channel_count)
                begin
                    $error("channel_count: expected %0d, got %0d",
                           want.data.channel_count, got.channel_count);
                    err_count++;
                end
                if (got.mapping_family != want.data.mapping_family)
                begin
                    $error("mapping_family: expected %0d, got %0d",
                           want.data.mapping_family, got.mapping_family);
                    err_count++;
                end
                if (got.input_rate != want.data.input_rate)
                begin
                    $error("input_rate: expected %0d, got %0d",
                           want.data.input_rate, got.input_rate);
                    err_count++;
                end
                if (got.layout_class != want.data.layout_class)
                begin
                    $error("layout_class: expected %0d, got %0d",
                           want.data.layout_class, got.layout_class);
                    err_count++;
                end
                if (got.tag_key != want.data.tag_key)
                begin
                    $error("tag_key: expected %0d, got %0d",
                           want.data.tag_key, got.tag_key);
                    err_count++;
                end
                if (got.tag_byte != want.data.tag_byte)
                begin
                    $error("tag_byte: expected %0d, got %0d",
                           want.data.tag_byte, got.tag_byte);
                    err_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either side.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[ogg_opus_header_tag_parser] ERROR");
            $finish;
        end
    end

    initial
    begin
        parser_reset();
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        write_reg(oohtp_pkg::REG_VENDOR_LIMIT, 25'd65535);
        write_reg(oohtp_pkg::REG_COMMENT_LIMIT, 25'h1ffffff);
        test_page_one();
        wait_results_drained();
        write_reg(oohtp_pkg::REG_VENDOR_LIMIT, 25'd20);
        test_page_two_start();
        test_directed_comments();
        wait_results_drained();
        write_reg(oohtp_pkg::REG_VENDOR_LIMIT, 25'd0);
        write_reg(oohtp_pkg::REG_COMMENT_LIMIT, 25'd300);
        test_random_comments();
        test_backpressure();
        wait_results_drained();
        test_cancel_at_end();
        wait_results_drained();
        repeat (20) @(negedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            err_count++;
        end
        if (err_count == 0)
            $display("[ogg_opus_header_tag_parser] OK");
        else
            $display("[ogg_opus_header_tag_parser] ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/oohtp_pkg.sv
rtl/ogg_opus_header_tag_parser.sv
rtl/oohtp_checker.sv
sim/tb.sv
